// File: src/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Widths, fixed-point constants and the hue fraction table shared by the core.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	// Port widths.
	localparam int HUE_W     = 15;
	localparam int FRAC_IN_W = 17;
	localparam int CHAN_W    = 8;
	localparam int NUM_CH    = 3;

	// Internal fixed point: 24 fraction bits.
	localparam int QF        = 24;
	localparam int IN_SHIFT  = QF - 16;
	localparam int VAL_W     = 29;
	localparam int HF_W      = 25;
	localparam int T_W       = 27;
	localparam int F_W       = 22;
	localparam int D6_W      = 32;
	localparam int PROD_W    = 54;
	localparam int LS_PROD_W = 2 * FRAC_IN_W;
	localparam int LS_W      = LS_PROD_W - IN_SHIFT;

	// Hue to turns: hue * 2^24 / 23040 = hue * 2^15 / 45.
	// The quotient by 45 comes from a reciprocal multiply that is exact
	// over the whole 15-bit input range.
	localparam int HUE_DIV         = 45;
	localparam int HUE_RECIP       = 1491309;
	localparam int HUE_RECIP_W     = 21;
	localparam int HUE_RECIP_SHIFT = 26;
	localparam int HR_PROD_W       = HUE_W + HUE_RECIP_W;
	localparam int DIV_W           = 10;
	localparam int REM_W           = 6;
	localparam int TBL_W           = HF_W - DIV_W;

	localparam logic [FRAC_IN_W-1:0] HALF_IN = FRAC_IN_W'(32768);

	localparam logic signed [T_W-1:0] ONE_T   = T_W'(16777216);
	localparam logic signed [T_W-1:0] THIRD_T = T_W'(5592405);

	localparam logic [HF_W-1:0] SIXTH_U     = HF_W'(2796202);
	localparam logic [HF_W-1:0] HALF_U      = HF_W'(8388608);
	localparam logic [HF_W-1:0] TWO_THIRD_U = HF_W'(11184810);

	localparam logic signed [VAL_W-1:0] ONE_V = VAL_W'(16777216);

	localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'd1 << QF) - 64'd1);

	typedef logic signed [VAL_W-1:0] level_t;
	typedef logic signed [T_W-1:0]   offset_t;
	typedef logic [TBL_W-1:0]        frac_tbl_t [HUE_DIV];

	// Hue offsets of the three channels: red leads by a third, blue lags.
	localparam offset_t CH_OFS [NUM_CH] = '{THIRD_T, '0, -THIRD_T};

	// Segment of the hue ramp that a channel falls into.
	typedef enum logic [1:0] {
		RGN_RISE,
		RGN_HIGH,
		RGN_FALL,
		RGN_LOW
	} region_t;

	// floor(r * 2^15 / 45) for each remainder r of hue by 45.
	function automatic frac_tbl_t build_frac_tbl();
		frac_tbl_t tbl;
		for (int i = 0; i < HUE_DIV; i++) begin
			tbl[i] = TBL_W'((i * (1 << TBL_W)) / HUE_DIV);
		end
		return tbl;
	endfunction

	localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

endpackage

// File: src/hsl_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter core
// Seven-stage pipeline that turns one HSL pixel per clock into 8-bit RGB.
// ----------------------------------------------------------------------------
//
//  channel   | handshake      | payload
//  ----------+----------------+---------------------------------------
//  request   | start / busy   | hue, saturation, lightness
//  result    | done (strobe)  | red, green, blue
//
// A request is taken at every edge with start high; busy never rises.
// Each result is shown on done, with its request's colour, for one cycle.
// Latency is set by the stage count: multipliers in stages one and five,
// hue wrap and ramp decode in stages three and four, clamp in stage seven.
// Reset clears only the valid bits of the stages; payload is not reset.
// The result side has no back pressure, so the pipeline never stalls.
module hsl_to_rgb_converter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [hsl2rgb_pkg::HUE_W-1:0]     hue,
	input  logic [hsl2rgb_pkg::FRAC_IN_W-1:0] saturation,
	input  logic [hsl2rgb_pkg::FRAC_IN_W-1:0] lightness,
	output logic                             done,
	output logic [hsl2rgb_pkg::CHAN_W-1:0]    red,
	output logic [hsl2rgb_pkg::CHAN_W-1:0]    green,
	output logic [hsl2rgb_pkg::CHAN_W-1:0]    blue
);
	import hsl2rgb_pkg::*;

	// Valid bits.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// Stage 1: products.
	logic [HUE_W-1:0]     hue_s1;
	logic [FRAC_IN_W-1:0] lit_s1, sat_s1;
	logic [LS_PROD_W-1:0] ls_prod_s1;
	logic [DIV_W-1:0]     hdiv_s1;

	// Stage 2: levels and hue in turns.
	level_t               q_s2, p_s2;
	logic [HF_W-1:0]      hf_s2;
	logic                 grey_s2;
	logic [FRAC_IN_W-1:0] lit_s2;

	// Stage 3: wrapped channel positions.
	logic [HF_W-1:0]      t_s3 [NUM_CH];
	level_t               q_s3, p_s3;
	logic signed [D6_W-1:0] d6_s3;
	logic                 grey_s3;
	logic [FRAC_IN_W-1:0] lit_s3;

	// Stage 4: ramp decode.
	region_t              rgn_s4 [NUM_CH];
	logic [F_W-1:0]       f_s4 [NUM_CH];
	level_t               q_s4, p_s4;
	logic signed [D6_W-1:0] d6_s4;
	logic                 grey_s4;
	logic [FRAC_IN_W-1:0] lit_s4;

	// Stage 5: ramp products.
	logic signed [PROD_W-1:0] prod_s5 [NUM_CH];
	region_t              rgn_s5 [NUM_CH];
	level_t               q_s5, p_s5;
	logic                 grey_s5;
	logic [FRAC_IN_W-1:0] lit_s5;

	// Stage 6: channel levels.
	level_t               v_s6 [NUM_CH];
	logic                 grey_s6;

	// Stage 7: output bytes.
	logic [CHAN_W-1:0]    rgb_s7 [NUM_CH];

	// ------------------------------------------------------------------
	// Combinational logic of each stage.
	// ------------------------------------------------------------------
	logic [HR_PROD_W-1:0] hue_recip_prod;
	logic [LS_PROD_W-1:0] ls_prod;

	assign hue_recip_prod = HR_PROD_W'(hue) * HR_PROD_W'(HUE_RECIP);
	assign ls_prod        = LS_PROD_W'(lightness) * LS_PROD_W'(saturation);

	logic [HUE_W-1:0] hue_rem_full;
	logic [REM_W-1:0] hue_rem;
	level_t           l_lv, s_lv, ls_lv;
	logic             lit_low;
	level_t           q_nx, p_nx;

	always_comb begin
		hue_rem_full = hue_s1 - HUE_W'(hdiv_s1) * HUE_W'(HUE_DIV);
		hue_rem      = hue_rem_full[REM_W-1:0];
		l_lv         = $signed(VAL_W'({lit_s1, IN_SHIFT'(0)}));
		s_lv         = $signed(VAL_W'({sat_s1, IN_SHIFT'(0)}));
		ls_lv        = $signed(VAL_W'(ls_prod_s1[LS_PROD_W-1:IN_SHIFT]));
		lit_low      = lit_s1 < HALF_IN;
		if (lit_low) begin
			q_nx = l_lv + ls_lv;
			p_nx = l_lv - ls_lv;
		end else begin
			q_nx = l_lv + s_lv - ls_lv;
			p_nx = l_lv - s_lv + ls_lv;
		end
	end

	offset_t              t_raw  [NUM_CH];
	offset_t              t_wrap [NUM_CH];
	level_t               d_nx;
	logic signed [D6_W-1:0] dx;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			t_raw[c] = $signed(T_W'(hf_s2)) + CH_OFS[c];
			// Only one wrap is applied, so a hue beyond a full turn can stay past two thirds.
			if (t_raw[c] < 0) begin
				t_wrap[c] = t_raw[c] + ONE_T;
			end else if (t_raw[c] > ONE_T) begin
				t_wrap[c] = t_raw[c] - ONE_T;
			end else begin
				t_wrap[c] = t_raw[c];
			end
		end
		d_nx = q_s2 - p_s2;
		dx   = D6_W'(d_nx);
	end

	region_t        rgn_nx [NUM_CH];
	logic [F_W-1:0] f_nx   [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			priority if (t_s3[c] < SIXTH_U) begin
				rgn_nx[c] = RGN_RISE;
				f_nx[c]   = t_s3[c][F_W-1:0];
			end else if (t_s3[c] < HALF_U) begin
				rgn_nx[c] = RGN_HIGH;
				f_nx[c]   = '0;
			end else if (t_s3[c] < TWO_THIRD_U) begin
				rgn_nx[c] = RGN_FALL;
				f_nx[c]   = F_W'(TWO_THIRD_U - t_s3[c]);
			end else begin
				rgn_nx[c] = RGN_LOW;
				f_nx[c]   = '0;
			end
		end
	end

	logic signed [PROD_W-1:0] prod_nx [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod_nx[c] = PROD_W'(d6_s4) * $signed(PROD_W'(f_s4[c]));
		end
	end

	// The ramp product is divided by 2^24 with truncation toward zero.
	logic signed [PROD_W-1:0] prod_bias [NUM_CH];
	logic signed [PROD_W-1:0] prod_quot [NUM_CH];
	level_t                   v_nx      [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod_bias[c] = prod_s5[c] + (prod_s5[c][PROD_W-1] ? TRUNC_BIAS : '0);
			prod_quot[c] = prod_bias[c] >>> QF;
			if (grey_s5) begin
				v_nx[c] = $signed(VAL_W'({lit_s5, IN_SHIFT'(0)}));
			end else begin
				unique case (rgn_s5[c])
					RGN_RISE, RGN_FALL: v_nx[c] = p_s5 + VAL_W'(prod_quot[c]);
					RGN_HIGH:           v_nx[c] = q_s5;
					RGN_LOW:            v_nx[c] = p_s5;
					default:            v_nx[c] = p_s5;
				endcase
			end
		end
	end

	logic [QF-1:0]        v_frac   [NUM_CH];
	logic [QF+CHAN_W-1:0] v_scaled [NUM_CH];
	logic [CHAN_W-1:0]    byte_nx  [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			v_frac[c]   = v_s6[c][QF-1:0];
			// Times 255 as a shift and a subtract.
			v_scaled[c] = {v_frac[c], CHAN_W'(0)} - (QF+CHAN_W)'(v_frac[c]);
			if (v_s6[c] <= 0) begin
				byte_nx[c] = '0;
			end else if (v_s6[c] >= ONE_V) begin
				byte_nx[c] = '1;
			end else begin
				byte_nx[c] = v_scaled[c][QF+CHAN_W-1:QF];
			end
		end
	end

	// ------------------------------------------------------------------
	// Registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		hue_s1     <= hue;
		lit_s1     <= lightness;
		sat_s1     <= saturation;
		ls_prod_s1 <= ls_prod;
		hdiv_s1    <= hue_recip_prod[HUE_RECIP_SHIFT +: DIV_W];

		q_s2    <= q_nx;
		p_s2    <= p_nx;
		hf_s2   <= {hdiv_s1, FRAC_TBL[hue_rem]};
		grey_s2 <= sat_s1 == '0;
		lit_s2  <= lit_s1;

		for (int c = 0; c < NUM_CH; c++) begin
			t_s3[c] <= HF_W'(t_wrap[c]);
		end
		q_s3    <= q_s2;
		p_s3    <= p_s2;
		d6_s3   <= (dx <<< 2) + (dx <<< 1);
		grey_s3 <= grey_s2;
		lit_s3  <= lit_s2;

		for (int c = 0; c < NUM_CH; c++) begin
			rgn_s4[c] <= rgn_nx[c];
			f_s4[c]   <= f_nx[c];
		end
		q_s4    <= q_s3;
		p_s4    <= p_s3;
		d6_s4   <= d6_s3;
		grey_s4 <= grey_s3;
		lit_s4  <= lit_s3;

		for (int c = 0; c < NUM_CH; c++) begin
			prod_s5[c] <= prod_nx[c];
			rgn_s5[c]  <= rgn_s4[c];
		end
		q_s5    <= q_s4;
		p_s5    <= p_s4;
		grey_s5 <= grey_s4;
		lit_s5  <= lit_s4;

		for (int c = 0; c < NUM_CH; c++) begin
			v_s6[c] <= v_nx[c];
		end
		grey_s6 <= grey_s5;

		for (int c = 0; c < NUM_CH; c++) begin
			rgb_s7[c] <= byte_nx[c];
		end
	end

	assign busy  = 1'b0;
	assign done  = valid_s7;
	assign red   = rgb_s7[0];
	assign green = rgb_s7[1];
	assign blue  = rgb_s7[2];

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##7 done)
		else $error("request did not produce a result seven cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result without a matching request");

	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && grey_s6) |=> ((red == green) && (green == blue)))
		else $error("zero saturation gave unequal channels");

	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |->
			((rgn_s4[0] == RGN_HIGH || rgn_s4[0] == RGN_LOW || f_s4[0] <= F_W'(SIXTH_U)) &&
			 (rgn_s4[1] == RGN_HIGH || rgn_s4[1] == RGN_LOW || f_s4[1] <= F_W'(SIXTH_U)) &&
			 (rgn_s4[2] == RGN_HIGH || rgn_s4[2] == RGN_LOW || f_s4[2] <= F_W'(SIXTH_U))))
		else $error("ramp factor exceeds one sixth");

endmodule
